/* rtl/ecev_pkg.sv */
// ecev_pkg: types, constants and codes shared by the encoder count and velocity block
// no dependencies; used by every module under rtl

package ecev_pkg;

    // wheel count that the port list carries
    localparam int MAX_WHEELS = 4;
    localparam int WHEELS_DEFAULT = 4;

    localparam int RAW_W = 16;
    localparam int CNT_W = 32;
    localparam int THR_W = 15;
    localparam int MASK_W = 4;
    localparam int SCALE_W = 32;
    localparam int TIME_W = 32;
    localparam int PROD_W = CNT_W + SCALE_W;
    localparam int NUM_W = PROD_W + 1;
    // quotient bits left once the saturation check has passed
    localparam int QUOT_W = 31;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [THR_W-1:0] WRAP_THR_RESET = 15'd16384;
    localparam logic [MASK_W-1:0] ENC_MASK_RESET = 4'd0;
    localparam logic [MASK_W-1:0] MOT_MASK_RESET = 4'd0;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd411775;

    localparam logic [CNT_W-1:0] WRAP_STEP = 32'h0001_0000;
    localparam logic [CNT_W-1:0] SPEED_MAX = 32'h7FFF_FFFF;
    localparam logic [CNT_W-1:0] SPEED_MIN = 32'h8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WRAP_THR  = 2'd0,
        CFG_ENC_MASK  = 2'd1,
        CFG_MOT_MASK  = 2'd2,
        CFG_VEL_SCALE = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COUNT,
        ST_MUL,
        ST_DSTART,
        ST_DWAIT,
        ST_DONE
    } seq_state_t;

    // result of the count extension for one wheel
    typedef struct packed {
        logic [CNT_W-1:0] offset;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] mag;
        logic             neg;
    } count_res_t;

    // divider status towards the sequencer
    typedef struct packed {
        logic done;
        logic sat;
    } div_status_t;

endpackage

/* rtl/ecev_count.sv */
// ecev_count: wrap detection, 32-bit extension and count delta for one wheel
// depends on ecev_pkg

module ecev_count
(
    input  logic [ecev_pkg::RAW_W-1:0] raw,
    input  logic [ecev_pkg::RAW_W-1:0] prev_raw,
    input  logic [ecev_pkg::CNT_W-1:0] offset,
    input  logic [ecev_pkg::CNT_W-1:0] prev_count,
    input  logic [ecev_pkg::THR_W-1:0] threshold,
    input  logic                       enc_neg,
    input  logic                       mot_keep,
    output ecev_pkg::count_res_t       res
);

    logic signed [ecev_pkg::RAW_W-1:0] diff;
    logic signed [ecev_pkg::RAW_W+1:0] diff_x;
    logic signed [ecev_pkg::RAW_W+1:0] thr_x;
    logic [ecev_pkg::CNT_W-1:0]        offset_new;
    logic [ecev_pkg::CNT_W-1:0]        count_pos;
    logic [ecev_pkg::CNT_W-1:0]        count;
    logic [ecev_pkg::CNT_W-1:0]        delta_raw;
    logic [ecev_pkg::CNT_W-1:0]        delta;

    always_comb
    begin
        diff = $signed(raw - prev_raw);
        diff_x = (ecev_pkg::RAW_W+2)'(diff);
        thr_x = $signed({3'b000, threshold});
        // a difference beyond the threshold either way means the counter wrapped
        if (diff_x > thr_x)
        begin
            offset_new = offset - ecev_pkg::WRAP_STEP;
        end
        else if (diff_x < -thr_x)
        begin
            offset_new = offset + ecev_pkg::WRAP_STEP;
        end
        else
        begin
            offset_new = offset;
        end
        count_pos = offset_new + {{(ecev_pkg::CNT_W-ecev_pkg::RAW_W){raw[ecev_pkg::RAW_W-1]}}, raw};
        count = enc_neg ? (ecev_pkg::CNT_W'(0) - count_pos) : count_pos;
        delta_raw = count - prev_count;
        delta = mot_keep ? delta_raw : (ecev_pkg::CNT_W'(0) - delta_raw);
        res.offset = offset_new;
        res.count = count;
        res.neg = delta[ecev_pkg::CNT_W-1];
        res.mag = delta[ecev_pkg::CNT_W-1] ? (ecev_pkg::CNT_W'(0) - delta) : delta;
    end

endmodule

/* rtl/ecev_div.sv */
// ecev_div: shared restoring divider, one quotient bit a cycle, with overflow check
// depends on ecev_pkg

module ecev_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ecev_pkg::NUM_W-1:0]  num,
    input  logic [ecev_pkg::TIME_W-1:0] den,
    output ecev_pkg::div_status_t       status,
    output logic [ecev_pkg::QUOT_W-1:0] quot
);

    localparam int HI_W = ecev_pkg::NUM_W - ecev_pkg::QUOT_W;
    localparam int CW = $clog2(ecev_pkg::QUOT_W + 1);

    logic                        busy_reg;
    logic                        busy_next;
    logic [CW-1:0]               cnt_reg;
    logic [CW-1:0]               cnt_next;
    logic                        sat_reg;
    logic                        sat_next;
    logic [ecev_pkg::TIME_W-1:0] den_reg;
    logic [ecev_pkg::TIME_W-1:0] rem_reg;
    logic [ecev_pkg::TIME_W-1:0] rem_next;
    logic [ecev_pkg::QUOT_W-1:0] low_reg;
    logic [ecev_pkg::QUOT_W-1:0] low_next;
    logic [HI_W-1:0]             num_hi;
    logic                        ovf;
    logic [ecev_pkg::TIME_W:0]   rem2;
    logic [ecev_pkg::TIME_W:0]   rem_sub;
    logic                        ge;

    always_comb
    begin
        num_hi = num[ecev_pkg::NUM_W-1:ecev_pkg::QUOT_W];
        // quotient of 2^31 or more saturates whatever its sign
        ovf = num_hi >= HI_W'(den);
        rem2 = {rem_reg, low_reg[ecev_pkg::QUOT_W-1]};
        rem_sub = rem2 - {1'b0, den_reg};
        ge = rem2 >= {1'b0, den_reg};
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        sat_next = sat_reg;
        rem_next = rem_reg;
        low_next = low_reg;
        if (start)
        begin
            busy_next = 1'b1;
            sat_next = ovf;
            cnt_next = ovf ? CW'(0) : CW'(ecev_pkg::QUOT_W);
            rem_next = num_hi[ecev_pkg::TIME_W-1:0];
            low_next = num[ecev_pkg::QUOT_W-1:0];
        end
        else if (busy_reg && (cnt_reg != CW'(0)))
        begin
            cnt_next = cnt_reg - CW'(1);
            rem_next = ge ? rem_sub[ecev_pkg::TIME_W-1:0] : rem2[ecev_pkg::TIME_W-1:0];
            low_next = {low_reg[ecev_pkg::QUOT_W-2:0], ge};
        end
        else if (busy_reg)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
            sat_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
            sat_reg <= sat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
        end
        rem_reg <= rem_next;
        low_reg <= low_next;
    end

    assign status.done = busy_reg && (cnt_reg == CW'(0));
    assign status.sat = sat_reg;
    assign quot = low_reg;

endmodule

/* rtl/encoder_count_extend_velocity.sv */
// encoder_count_extend_velocity: top level, sequencer, wheel state and output register
// depends on ecev_pkg, ecev_count and ecev_div
//
// usage
//   input channel (in_valid / in_stall) carries one snapshot word: mode, four raw
//   16-bit counters and a millisecond timestamp. mode 0 samples, mode 1 clears the
//   wrap offsets, last raw counts and last counts and yields no result word.
//   output channel (out_valid / out_stall) carries the extended counts, Q16.16
//   speeds in rad/s (saturated) and the echoed timestamp, one word per sample.
//   config channel (cfg_valid / cfg_ready, always ready) writes the threshold, the
//   two sign masks and the velocity scale; write it only while the block is idle.
// flow
//   a sample is worked one wheel at a time through one 32x32 multiplier and one
//   restoring divider giving a quotient bit per cycle. each wheel passes the count,
//   multiply, divider start and divider wait steps, with no quotient bits worked
//   when its speed saturates; after the last wheel the done step loads the output
//   register and returns to idle. a reset word leaves the block idle.
//   in_stall stays high while a sample is at work; the result sits in an output
//   register, so a new word is taken while it waits. a sample that finishes while
//   the receiver still stalls the previous word holds in the last step until free.
// reset
//   rst_n clears all wheel tracking, the previous timestamp and the output valid,
//   and loads the register defaults.

module encoder_count_extend_velocity
#(
    parameter int WHEELS = ecev_pkg::WHEELS_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                mode,
    input  logic signed [ecev_pkg::RAW_W-1:0]   raw_count_a,
    input  logic signed [ecev_pkg::RAW_W-1:0]   raw_count_b,
    input  logic signed [ecev_pkg::RAW_W-1:0]   raw_count_c,
    input  logic signed [ecev_pkg::RAW_W-1:0]   raw_count_d,
    input  logic [ecev_pkg::TIME_W-1:0]         time_ms,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [ecev_pkg::CNT_W-1:0]   ext_count_a,
    output logic signed [ecev_pkg::CNT_W-1:0]   ext_count_b,
    output logic signed [ecev_pkg::CNT_W-1:0]   ext_count_c,
    output logic signed [ecev_pkg::CNT_W-1:0]   ext_count_d,
    output logic signed [ecev_pkg::CNT_W-1:0]   speed_a,
    output logic signed [ecev_pkg::CNT_W-1:0]   speed_b,
    output logic signed [ecev_pkg::CNT_W-1:0]   speed_c,
    output logic signed [ecev_pkg::CNT_W-1:0]   speed_d,
    output logic [ecev_pkg::TIME_W-1:0]         sample_time,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ecev_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ecev_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // wheels above the port count act as the port count
    localparam int ACTIVE = (WHEELS > ecev_pkg::MAX_WHEELS) ? ecev_pkg::MAX_WHEELS : WHEELS;
    localparam int WIDX_W = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;

    // configuration registers
    logic [ecev_pkg::THR_W-1:0]   thr_reg;
    logic [ecev_pkg::MASK_W-1:0]  enc_mask_reg;
    logic [ecev_pkg::MASK_W-1:0]  mot_mask_reg;
    logic [ecev_pkg::SCALE_W-1:0] scale_reg;

    // sequencer
    ecev_pkg::seq_state_t state_reg;
    ecev_pkg::seq_state_t state_next;
    logic [WIDX_W-1:0]    wheel_reg;
    logic                 last_wheel;
    logic                 accept;
    logic                 div_start;
    logic                 load_out;

    // wheel tracking
    logic [ecev_pkg::RAW_W-1:0]  prev_raw_reg [ACTIVE];
    logic [ecev_pkg::CNT_W-1:0]  wrap_off_reg [ACTIVE];
    logic [ecev_pkg::CNT_W-1:0]  prev_cnt_reg [ACTIVE];
    logic [ecev_pkg::TIME_W-1:0] prev_time_reg;

    // snapshot and working values
    logic [ecev_pkg::RAW_W-1:0]  raw_in [ecev_pkg::MAX_WHEELS];
    logic [ecev_pkg::RAW_W-1:0]  raw_reg [ACTIVE];
    logic [ecev_pkg::TIME_W-1:0] time_reg;
    logic [ecev_pkg::TIME_W-1:0] dt_raw;
    logic [ecev_pkg::TIME_W-1:0] dt_reg;
    logic [ecev_pkg::CNT_W-1:0]  ext_reg [ACTIVE];
    logic [ecev_pkg::CNT_W-1:0]  spd_reg [ACTIVE];
    logic [ecev_pkg::CNT_W-1:0]  mag_reg;
    logic                        neg_reg;
    logic [ecev_pkg::PROD_W-1:0] prod_w;
    logic [ecev_pkg::PROD_W-1:0] prod_reg;
    logic [ecev_pkg::NUM_W-1:0]  num_w;
    logic [ecev_pkg::CNT_W-1:0]  speed_w;
    logic [ecev_pkg::CNT_W-1:0]  quot_x;

    ecev_pkg::count_res_t  cnt_res;
    ecev_pkg::div_status_t div_st;
    logic [ecev_pkg::QUOT_W-1:0] div_quot;

    // output register
    logic                        out_valid_reg;
    logic [ecev_pkg::CNT_W-1:0]  out_ext_reg [ACTIVE];
    logic [ecev_pkg::CNT_W-1:0]  out_spd_reg [ACTIVE];
    logic [ecev_pkg::TIME_W-1:0] out_time_reg;
    logic [ecev_pkg::CNT_W-1:0]  ext_vec [ecev_pkg::MAX_WHEELS];
    logic [ecev_pkg::CNT_W-1:0]  spd_vec [ecev_pkg::MAX_WHEELS];

    assign raw_in[0] = raw_count_a;
    assign raw_in[1] = raw_count_b;
    assign raw_in[2] = raw_count_c;
    assign raw_in[3] = raw_count_d;

    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= ecev_pkg::WRAP_THR_RESET;
            enc_mask_reg <= ecev_pkg::ENC_MASK_RESET;
            mot_mask_reg <= ecev_pkg::MOT_MASK_RESET;
            scale_reg <= ecev_pkg::SCALE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ecev_pkg::CFG_WRAP_THR:  thr_reg <= cfg_data[ecev_pkg::THR_W-1:0];
                ecev_pkg::CFG_ENC_MASK:  enc_mask_reg <= cfg_data[ecev_pkg::MASK_W-1:0];
                ecev_pkg::CFG_MOT_MASK:  mot_mask_reg <= cfg_data[ecev_pkg::MASK_W-1:0];
                ecev_pkg::CFG_VEL_SCALE: scale_reg <= cfg_data[ecev_pkg::SCALE_W-1:0];
                default:                 thr_reg <= thr_reg;
            endcase
        end
    end

    assign last_wheel = (wheel_reg == WIDX_W'(ACTIVE - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ecev_pkg::ST_IDLE:
            begin
                if (in_valid && !mode)
                begin
                    state_next = ecev_pkg::ST_COUNT;
                end
            end
            ecev_pkg::ST_COUNT:  state_next = ecev_pkg::ST_MUL;
            ecev_pkg::ST_MUL:    state_next = ecev_pkg::ST_DSTART;
            ecev_pkg::ST_DSTART: state_next = ecev_pkg::ST_DWAIT;
            ecev_pkg::ST_DWAIT:
            begin
                if (div_st.done)
                begin
                    state_next = last_wheel ? ecev_pkg::ST_DONE : ecev_pkg::ST_COUNT;
                end
            end
            ecev_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ecev_pkg::ST_IDLE;
                end
            end
            default: state_next = ecev_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall = 1'b1;
        div_start = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ecev_pkg::ST_IDLE:   in_stall = 1'b0;
            ecev_pkg::ST_DSTART: div_start = 1'b1;
            ecev_pkg::ST_DONE:   load_out = !out_valid_reg || !out_stall;
            default:             in_stall = 1'b1;
        endcase
    end

    assign accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ecev_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // count extension for the wheel in hand
    ecev_count u_count
    (
        .raw        (raw_reg[wheel_reg]),
        .prev_raw   (prev_raw_reg[wheel_reg]),
        .offset     (wrap_off_reg[wheel_reg]),
        .prev_count (prev_cnt_reg[wheel_reg]),
        .threshold  (thr_reg),
        .enc_neg    (enc_mask_reg[wheel_reg]),
        .mot_keep   (mot_mask_reg[wheel_reg]),
        .res        (cnt_res)
    );

    // elapsed time; a zero difference is replaced by one when it is registered
    assign dt_raw = time_ms - prev_time_reg;

    // tracking state and wheel counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ACTIVE; i++)
            begin
                prev_raw_reg[i] <= '0;
                wrap_off_reg[i] <= '0;
                prev_cnt_reg[i] <= '0;
            end
            prev_time_reg <= '0;
            wheel_reg <= '0;
        end
        else
        begin
            if (accept && mode)
            begin
                for (int i = 0; i < ACTIVE; i++)
                begin
                    prev_raw_reg[i] <= '0;
                    wrap_off_reg[i] <= '0;
                    prev_cnt_reg[i] <= '0;
                end
            end
            else if (accept)
            begin
                prev_time_reg <= time_ms;
                wheel_reg <= '0;
            end
            if (state_reg == ecev_pkg::ST_COUNT)
            begin
                prev_raw_reg[wheel_reg] <= raw_reg[wheel_reg];
                wrap_off_reg[wheel_reg] <= cnt_res.offset;
                prev_cnt_reg[wheel_reg] <= cnt_res.count;
            end
            if ((state_reg == ecev_pkg::ST_DWAIT) && div_st.done && !last_wheel)
            begin
                wheel_reg <= wheel_reg + WIDX_W'(1);
            end
        end
    end

    // multiply, then the rounding half of the divisor
    assign prod_w = mag_reg * scale_reg;
    assign num_w = ecev_pkg::NUM_W'(prod_reg) + ecev_pkg::NUM_W'(dt_reg[ecev_pkg::TIME_W-1:1]);

    always_ff @(posedge clk)
    begin
        if (accept && !mode)
        begin
            for (int i = 0; i < ACTIVE; i++)
            begin
                raw_reg[i] <= raw_in[i];
            end
            time_reg <= time_ms;
            dt_reg <= (dt_raw == '0) ? ecev_pkg::TIME_W'(1) : dt_raw;
        end
        if (state_reg == ecev_pkg::ST_COUNT)
        begin
            ext_reg[wheel_reg] <= cnt_res.count;
            mag_reg <= cnt_res.mag;
            neg_reg <= cnt_res.neg;
        end
        if (state_reg == ecev_pkg::ST_MUL)
        begin
            prod_reg <= prod_w;
        end
        if ((state_reg == ecev_pkg::ST_DWAIT) && div_st.done)
        begin
            spd_reg[wheel_reg] <= speed_w;
        end
    end

    ecev_div u_div
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (num_w),
        .den    (dt_reg),
        .status (div_st),
        .quot   (div_quot)
    );

    // sign and saturation of the rounded magnitude
    always_comb
    begin
        quot_x = {1'b0, div_quot};
        if (div_st.sat)
        begin
            speed_w = neg_reg ? ecev_pkg::SPEED_MIN : ecev_pkg::SPEED_MAX;
        end
        else
        begin
            speed_w = neg_reg ? (ecev_pkg::CNT_W'(0) - quot_x) : quot_x;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            for (int i = 0; i < ACTIVE; i++)
            begin
                out_ext_reg[i] <= ext_reg[i];
                out_spd_reg[i] <= spd_reg[i];
            end
            out_time_reg <= time_reg;
        end
    end

    // wheels beyond the active count read as zero
    for (genvar g = 0; g < ecev_pkg::MAX_WHEELS; g++)
    begin : g_out
        if (g < ACTIVE)
        begin : g_act
            assign ext_vec[g] = out_ext_reg[g];
            assign spd_vec[g] = out_spd_reg[g];
        end
        else
        begin : g_off
            assign ext_vec[g] = '0;
            assign spd_vec[g] = '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign ext_count_a = ext_vec[0];
    assign ext_count_b = ext_vec[1];
    assign ext_count_c = ext_vec[2];
    assign ext_count_d = ext_vec[3];
    assign speed_a = spd_vec[0];
    assign speed_b = spd_vec[1];
    assign speed_c = spd_vec[2];
    assign speed_d = spd_vec[3];
    assign sample_time = out_time_reg;

endmodule

/* rtl/ecev_checker.sv */
// ecev_checker: port-level assertions for encoder_count_extend_velocity, with its bind
// depends on ecev_pkg and the top level's port list

module ecev_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              mode,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [ecev_pkg::TIME_W-1:0]       sample_time,
    input logic signed [ecev_pkg::CNT_W-1:0] speed_a
);

    // a sample keeps the block busy in the next cycle
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !mode |=> in_stall)
        else $error("sample word accepted but block not busy");

    // a tracking reset never produces a result word
    a_reset_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && mode && !out_valid |=> !out_valid)
        else $error("result word after a reset word");

    // a result appears only at the end of a busy period
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result word without work in progress");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample_time) && $stable(speed_a))
        else $error("stalled result word changed");

endmodule

bind encoder_count_extend_velocity ecev_checker u_ecev_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sample_time (sample_time),
    .speed_a     (speed_a)
);

/* bench/encoder_count_extend_velocity_test.sv */
// encoder_count_extend_velocity_test: self-checking bench for the encoder count and velocity block
// needs ecev_pkg and encoder_count_extend_velocity from rtl, and through it ecev_count and ecev_div

module encoder_count_extend_velocity_test;
    timeunit 1ns;
    timeprecision 1ps;

    // widths taken from the package
    localparam int MAX_WHEELS     = ecev_pkg::MAX_WHEELS;
    localparam int RAW_W          = ecev_pkg::RAW_W;
    localparam int CNT_W          = ecev_pkg::CNT_W;
    localparam int THR_W          = ecev_pkg::THR_W;
    localparam int MASK_W         = ecev_pkg::MASK_W;
    localparam int SCALE_W        = ecev_pkg::SCALE_W;
    localparam int TIME_W         = ecev_pkg::TIME_W;
    localparam int CFG_IDX_W      = ecev_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W     = ecev_pkg::CFG_DATA_W;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 7;
    // long enough for the worst sample on every wheel, with some margin on top
    localparam int SETTLE_CYCLES  = 35 * MAX_WHEELS + 2 + 20;
    localparam int HOLD_CYCLES    = 600;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int RAND_PER_PHASE = 100;
    localparam int RAND_PHASES    = 8;
    localparam int MAX_REPORTS    = 10;

    // one snapshot word as offered on the input channel
    typedef struct packed {
        logic                                mode;
        logic [MAX_WHEELS-1:0][RAW_W-1:0]    raw;
        logic [TIME_W-1:0]                   stamp;
    } snapshot_t;

    // one result word as expected on the output channel
    typedef struct packed {
        logic [MAX_WHEELS-1:0][CNT_W-1:0]    count;
        logic [MAX_WHEELS-1:0][CNT_W-1:0]    speed;
        logic [TIME_W-1:0]                   stamp;
    } wheel_report_t;

    // clock, reset and block ports
    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic                       mode = 1'b0;
    logic signed [RAW_W-1:0]    raw_count_a = '0;
    logic signed [RAW_W-1:0]    raw_count_b = '0;
    logic signed [RAW_W-1:0]    raw_count_c = '0;
    logic signed [RAW_W-1:0]    raw_count_d = '0;
    logic [TIME_W-1:0]          time_ms = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [CNT_W-1:0]    ext_count_a;
    logic signed [CNT_W-1:0]    ext_count_b;
    logic signed [CNT_W-1:0]    ext_count_c;
    logic signed [CNT_W-1:0]    ext_count_d;
    logic signed [CNT_W-1:0]    speed_a;
    logic signed [CNT_W-1:0]    speed_b;
    logic signed [CNT_W-1:0]    speed_c;
    logic signed [CNT_W-1:0]    speed_d;
    logic [TIME_W-1:0]          sample_time;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;

    // words waiting to be offered, and result words still owed by the block
    snapshot_t                  snap_queue[$];
    wheel_report_t              report_queue[$];
    snapshot_t                  on_bus = '0;

    // idling control: percentage of cycles each side holds back
    int unsigned                tx_idle_pct = 31;
    int unsigned                rx_idle_pct = 62;
    logic                       rx_hold = 1'b0;

    int unsigned                fault_count = 0;
    int unsigned                cycle_count = 0;

    // shadow copy of the registers, loaded with the reset defaults
    logic [THR_W-1:0]           thr_copy = ecev_pkg::WRAP_THR_RESET;
    logic [MASK_W-1:0]          enc_copy = ecev_pkg::ENC_MASK_RESET;
    logic [MASK_W-1:0]          mot_copy = ecev_pkg::MOT_MASK_RESET;
    logic [SCALE_W-1:0]         scale_copy = ecev_pkg::SCALE_RESET;

    // shadow copy of the per-wheel tracking state
    logic [RAW_W-1:0]           last_raw [MAX_WHEELS] = '{default: '0};
    logic [CNT_W-1:0]           wrap_off [MAX_WHEELS] = '{default: '0};
    logic [CNT_W-1:0]           last_cnt [MAX_WHEELS] = '{default: '0};
    logic [TIME_W-1:0]          last_stamp = '0;

    // generator state for well-formed motion: encoder positions, rates and a clock
    logic [RAW_W-1:0]           sim_pos [MAX_WHEELS] = '{default: '0};
    int                         sim_rate [MAX_WHEELS] = '{default: 0};
    logic [TIME_W-1:0]          sim_stamp = '0;

    encoder_count_extend_velocity dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .raw_count_a (raw_count_a),
        .raw_count_b (raw_count_b),
        .raw_count_c (raw_count_c),
        .raw_count_d (raw_count_d),
        .time_ms     (time_ms),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .ext_count_a (ext_count_a),
        .ext_count_b (ext_count_b),
        .ext_count_c (ext_count_c),
        .ext_count_d (ext_count_d),
        .speed_a     (speed_a),
        .speed_b     (speed_b),
        .speed_c     (speed_c),
        .speed_d     (speed_d),
        .sample_time (sample_time),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // |delta| * scale / dt, rounded to nearest with ties away from zero, sign put back
    // afterwards and saturated to the signed 32-bit range
    function automatic logic [CNT_W-1:0] q16_speed(input logic [CNT_W-1:0] delta,
                                                   input logic [TIME_W-1:0] dt);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] quot;
        neg = delta[CNT_W-1];
        mag = {32'd0, (neg ? (32'd0 - delta) : delta)};
        quot = (mag * {32'd0, scale_copy} + {33'd0, dt[TIME_W-1:1]}) / {32'd0, dt};
        if (neg)
        begin
            return (quot >= 64'h0000_0000_8000_0000) ? ecev_pkg::SPEED_MIN
                                                     : (32'd0 - quot[31:0]);
        end
        return (quot > 64'h0000_0000_7FFF_FFFF) ? ecev_pkg::SPEED_MAX : quot[31:0];
    endfunction

    // advance the shadow tracking by one accepted word and queue the result it owes
    task automatic track_snapshot(input snapshot_t s);
        wheel_report_t           rep;
        logic [TIME_W-1:0]       dt;
        logic signed [RAW_W-1:0] step;
        int                      diff;
        int                      thr;
        logic [CNT_W-1:0]        cnt;
        logic [CNT_W-1:0]        delta;
        if (s.mode)
        begin
            // tracking reset: offsets and history cleared, timestamp kept, no word out
            for (int w = 0; w < MAX_WHEELS; w++)
            begin
                last_raw[w] = '0;
                wrap_off[w] = '0;
                last_cnt[w] = '0;
            end
            return;
        end
        dt = s.stamp - last_stamp;
        if (dt == '0)
            dt = 1;
        thr = int'(thr_copy);
        rep = '0;
        for (int w = 0; w < MAX_WHEELS; w++)
        begin
            // 16-bit difference against the last raw value decides a counter wrap
            step = s.raw[w] - last_raw[w];
            diff = step;
            if (diff > thr)
                wrap_off[w] = wrap_off[w] - ecev_pkg::WRAP_STEP;
            else if (diff < -thr)
                wrap_off[w] = wrap_off[w] + ecev_pkg::WRAP_STEP;
            last_raw[w] = s.raw[w];
            cnt = wrap_off[w] + {{(CNT_W-RAW_W){s.raw[w][RAW_W-1]}}, s.raw[w]};
            if (enc_copy[w])
                cnt = 32'd0 - cnt;
            // delta is negated unless the motor sign bit says otherwise
            delta = cnt - last_cnt[w];
            if (!mot_copy[w])
                delta = 32'd0 - delta;
            rep.count[w] = cnt;
            rep.speed[w] = q16_speed(delta, dt);
            last_cnt[w] = cnt;
        end
        last_stamp = s.stamp;
        rep.stamp = s.stamp;
        report_queue.push_back(rep);
    endtask

    // driver: feeds words from snap_queue, holding the payload while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                track_snapshot(on_bus);
            if (!in_valid || !in_stall)
            begin
                if (snap_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    on_bus = snap_queue.pop_front();
                    in_valid    <= 1'b1;
                    mode        <= on_bus.mode;
                    raw_count_a <= on_bus.raw[0];
                    raw_count_b <= on_bus.raw[1];
                    raw_count_c <= on_bus.raw[2];
                    raw_count_d <= on_bus.raw[3];
                    time_ms     <= on_bus.stamp;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display("mismatch %s: expected %h, got %h", what, want, got);
    endtask

    // compare one accepted result word with the oldest one owed
    task automatic check_report();
        wheel_report_t got;
        wheel_report_t want;
        got.count = {ext_count_d, ext_count_c, ext_count_b, ext_count_a};
        got.speed = {speed_d, speed_c, speed_b, speed_a};
        got.stamp = sample_time;
        if (report_queue.size() == 0)
        begin
            fault_count++;
            if (fault_count <= MAX_REPORTS)
                $display("unexpected result word, sample_time %h", got.stamp);
            return;
        end
        want = report_queue.pop_front();
        for (int w = 0; w < MAX_WHEELS; w++)
        begin
            if (got.count[w] !== want.count[w])
                note_mismatch($sformatf("ext_count wheel %0d", w), want.count[w], got.count[w]);
            if (got.speed[w] !== want.speed[w])
                note_mismatch($sformatf("speed wheel %0d", w), want.speed[w], got.speed[w]);
        end
        if (got.stamp !== want.stamp)
            note_mismatch("sample_time", want.stamp, got.stamp);
    endtask

    // monitor: checks result words and drives the receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_report();
            out_stall <= rx_hold || ($urandom_range(99) < rx_idle_pct);
        end
    end

    task automatic push_snap(input logic m, input logic [RAW_W-1:0] a, input logic [RAW_W-1:0] b,
                             input logic [RAW_W-1:0] c, input logic [RAW_W-1:0] d,
                             input logic [TIME_W-1:0] t);
        snapshot_t s;
        s.mode = m;
        s.raw = {d, c, b, a};
        s.stamp = t;
        snap_queue.push_back(s);
    endtask

    // mostly smooth motion with a steady clock; some resets and some pure noise
    task automatic gen_random(input int count);
        snapshot_t   s;
        int unsigned pick;
        int unsigned lim;
        int          step;
        repeat (count)
        begin
            pick = $urandom_range(99);
            s.mode = 1'b0;
            s.raw = {$urandom, $urandom};
            s.stamp = $urandom;
            if (pick < 6)
            begin
                s.mode = 1'b1;
            end
            else if (pick >= 16)
            begin
                if ($urandom_range(9) == 0)
                begin
                    // new rates: slow, brisk, or close to the half-range threshold
                    for (int w = 0; w < MAX_WHEELS; w++)
                    begin
                        case ($urandom_range(2))
                            0: lim = 300;
                            1: lim = 6000;
                            default: lim = 32767;
                        endcase
                        sim_rate[w] = int'($urandom_range(2 * lim)) - int'(lim);
                    end
                end
                for (int w = 0; w < MAX_WHEELS; w++)
                begin
                    step = sim_rate[w] + int'($urandom_range(8)) - 4;
                    sim_pos[w] = sim_pos[w] + step[RAW_W-1:0];
                    s.raw[w] = sim_pos[w];
                end
                // an occasional repeated timestamp gives zero elapsed time
                if ($urandom_range(15) != 0)
                    sim_stamp = sim_stamp + $urandom_range(1, 60);
                s.stamp = sim_stamp;
            end
            snap_queue.push_back(s);
        end
    endtask

    // one register write; the shadow copy follows only once the write has gone in
    task automatic write_reg(input ecev_pkg::cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            ecev_pkg::CFG_WRAP_THR:  thr_copy = data[THR_W-1:0];
            ecev_pkg::CFG_ENC_MASK:  enc_copy = data[MASK_W-1:0];
            ecev_pkg::CFG_MOT_MASK:  mot_copy = data[MASK_W-1:0];
            ecev_pkg::CFG_VEL_SCALE: scale_copy = data[SCALE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic [THR_W-1:0] thr, input logic [MASK_W-1:0] enc,
                                 input logic [MASK_W-1:0] mot, input logic [SCALE_W-1:0] scale);
        write_reg(ecev_pkg::CFG_WRAP_THR, {{(CFG_DATA_W-THR_W){1'b0}}, thr});
        write_reg(ecev_pkg::CFG_ENC_MASK, {{(CFG_DATA_W-MASK_W){1'b0}}, enc});
        write_reg(ecev_pkg::CFG_MOT_MASK, {{(CFG_DATA_W-MASK_W){1'b0}}, mot});
        write_reg(ecev_pkg::CFG_VEL_SCALE, scale);
    endtask

    // wait until every word is in and every result out, then let a reset word finish
    task automatic settle_block();
        @(negedge clk);
        while (snap_queue.size() != 0 || in_valid || report_queue.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        logic [THR_W-1:0]   thr_v;
        logic [MASK_W-1:0]  enc_v;
        logic [MASK_W-1:0]  mot_v;
        logic [SCALE_W-1:0] scale_v;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed words under the reset defaults
        @(negedge clk);
        push_snap(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000); // zero elapsed
        push_snap(1'b0, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 32'h0000_0000); // big jumps wrap
        push_snap(1'b0, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001, 32'h0000_0001);
        push_snap(1'b0, 16'hC000, 16'h3FFF, 16'hBFFF, 16'h4001, 32'h0000_0002); // on threshold
        push_snap(1'b0, 16'h0064, 16'h00C8, 16'h012C, 16'h0190, 32'hFFFF_FFFF);
        push_snap(1'b0, 16'h0065, 16'h00C6, 16'h0131, 16'h018A, 32'h0000_0004); // clock wraps
        push_snap(1'b1, 16'h7FFF, 16'h8000, 16'h5555, 16'hAAAA, 32'hFFFF_FFFF); // tracking reset
        push_snap(1'b0, 16'h0010, 16'hFFF0, 16'h0100, 16'hFF00, 32'h0000_0010);
        push_snap(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000);
        push_snap(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0011);
        settle_block();

        // zero threshold, mixed signs and the largest scale: saturation both ways
        apply_setting(15'd0, 4'b1010, 4'b0101, 32'hFFFF_FFFF);
        @(negedge clk);
        push_snap(1'b0, 16'h0001, 16'hFFFF, 16'h0002, 16'hFFFE, 32'h0000_0020); // any step wraps
        push_snap(1'b0, 16'h0001, 16'hFFFF, 16'h0002, 16'hFFFE, 32'h0000_0020); // no step
        push_snap(1'b0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 32'h0000_0021);
        push_snap(1'b0, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 32'h0000_0022);
        push_snap(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h8000_0000); // long interval
        push_snap(1'b1, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 32'h0000_0000);
        push_snap(1'b0, 16'h0005, 16'hFFFB, 16'h7FFF, 16'h8000, 32'h8000_0001);
        settle_block();

        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            thr_v = 15'($urandom_range(1, 32767));
            enc_v = 4'($urandom);
            mot_v = 4'($urandom);
            scale_v = $urandom;
            case (phase)
                0:
                begin
                    thr_v = ecev_pkg::WRAP_THR_RESET;
                    enc_v = 4'b0000;
                    mot_v = 4'b0000;
                    scale_v = ecev_pkg::SCALE_RESET;
                end
                1:
                begin
                    thr_v = 15'd1;
                    enc_v = 4'b1111;
                    mot_v = 4'b1111;
                    scale_v = 32'd1;
                end
                2:
                begin
                    thr_v = 15'd32767;
                    scale_v = 32'hFFFF_FFFF;
                end
                4:
                begin
                    thr_v = 15'd0;
                    enc_v = 4'b0101;
                    mot_v = 4'b1010;
                    scale_v = $urandom_range(1, 1000000);
                end
                7:
                begin
                    thr_v = ecev_pkg::WRAP_THR_RESET;
                    scale_v = ecev_pkg::SCALE_RESET;
                end
                default: ;
            endcase

            // idling pattern swaps from phase 3 on, then stops from phase 6 on
            if (phase == 3)
            begin
                tx_idle_pct = 62;
                rx_idle_pct = 31;
            end
            else if (phase == 6)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            apply_setting(thr_v, enc_v, mot_v, scale_v);
            @(negedge clk);

            if (phase == 6)
            begin
                // receiver holds off long enough for the output register and the
                // sequencer to fill, while the sender keeps words on offer
                gen_random(12);
                fork
                    begin
                        rx_hold = 1'b1;
                        repeat (HOLD_CYCLES) @(negedge clk);
                        rx_hold = 1'b0;
                    end
                join_none
                @(negedge clk);
                while (rx_hold)
                    @(negedge clk);
            end

            gen_random(RAND_PER_PHASE);
            settle_block();
        end

        if (report_queue.size() != 0)
        begin
            fault_count += report_queue.size();
            $display("%0d result words never arrived", report_queue.size());
        end

        if (fault_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* filelist.f */
rtl/ecev_pkg.sv
rtl/ecev_count.sv
rtl/ecev_div.sv
rtl/encoder_count_extend_velocity.sv
rtl/ecev_checker.sv
bench/encoder_count_extend_velocity_test.sv
